// ===== rtl/core/ole_pkg.sv =====
// ----------------------------------------------------------------------------
// ole_pkg
// Operation codes and the control word that walks the cell chain.
// ----------------------------------------------------------------------------
package ole_pkg;

   localparam int IN_WIDTH    = 32;
   localparam int COUNT_WIDTH = 5;

   typedef enum logic [2:0] {
      OP_FRONT   = 3'd0,
      OP_BACK    = 3'd1,
      OP_ORDERED = 3'd2,
      OP_SEARCH  = 3'd3,
      OP_REMOVE  = 3'd4
   } op_type;

   // shift: insert has started moving entries down, or search/remove matched
   typedef struct packed {
      logic   act;
      op_type kind;
      logic   shift;
   } ctl_type;

endpackage

// ===== rtl/core/ole_cell.sv =====
// ----------------------------------------------------------------------------
// ole_cell
// One list slot. Applies the passing operation to its entry and hands the
// operation on to the next slot in the cycle after.
// ----------------------------------------------------------------------------
module ole_cell #(
   parameter int WIDTH = 32,
   parameter int CNT_W = 5,
   parameter int INDEX = 0
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [CNT_W-1:0]        count,
   input  ole_pkg::ctl_type        ctl_i,
   input  logic signed [WIDTH-1:0] v_i,
   input  logic [WIDTH-1:0]        carry_i,
   input  logic [WIDTH-1:0]        nxt_value,
   output logic [WIDTH-1:0]        value_o,
   output ole_pkg::ctl_type        ctl_o,
   output logic signed [WIDTH-1:0] v_o,
   output logic [WIDTH-1:0]        carry_o
);
   import ole_pkg::*;

   localparam logic [CNT_W-1:0] IDX = CNT_W'(INDEX);

   logic [WIDTH-1:0]        value_ff, value_in;
   ctl_type                 ctl_ff, ctl_in;
   logic signed [WIDTH-1:0] v_ff;
   logic [WIDTH-1:0]        carry_ff, carry_in;

   logic live, at_end, past_end, own_lt_v, v_lt_own, eq, begin_here;

   assign live     = IDX < count;
   assign at_end   = IDX == count;
   assign past_end = IDX > count;
   assign own_lt_v = $signed(value_ff) < v_i;
   assign v_lt_own = v_i < $signed(value_ff);
   assign eq       = value_ff == v_i;

   always_comb begin
      begin_here = 1'b0;
      case (ctl_i.kind)
         OP_FRONT:   begin_here = (INDEX == 0);
         OP_BACK:    begin_here = at_end;
         // head goes first only when the list is empty or the value is below it; equal lands after
         OP_ORDERED: begin_here = (INDEX == 0) ? (at_end || v_lt_own)
                                               : (at_end || (live && !own_lt_v));
         default:    begin_here = 1'b0;
      endcase
   end

   always_comb begin
      value_in = value_ff;
      ctl_in   = ctl_i;
      carry_in = carry_i;
      if (ctl_i.act) begin
         case (ctl_i.kind)
            OP_FRONT, OP_BACK, OP_ORDERED: begin
               if (!ctl_i.shift && begin_here) begin
                  value_in     = v_i;
                  carry_in     = value_ff;
                  ctl_in.shift = 1'b1;
               end else if (ctl_i.shift && !past_end) begin
                  value_in = carry_i;
                  carry_in = value_ff;
               end
            end
            OP_SEARCH: begin
               if (live && eq) ctl_in.shift = 1'b1;
            end
            OP_REMOVE: begin
               // after the first match every live entry pulls its successor up
               if (live && (ctl_i.shift || eq)) begin
                  value_in     = nxt_value;
                  ctl_in.shift = 1'b1;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      v_ff     <= v_i;
      carry_ff <= carry_in;
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_in;
      end
   end

   assign value_o = value_ff;
   assign ctl_o   = ctl_ff;
   assign v_o     = v_ff;
   assign carry_o = carry_ff;

endmodule

// ===== rtl/core/ordered_list_engine.sv =====
// ----------------------------------------------------------------------------
// ordered_list_engine
// Bounded list of signed values: front, back and ordered insert, search and
// remove of the first equal entry, built as a chain of slot cells.
// ----------------------------------------------------------------------------
// An operation accepted while busy is low travels down the DEPTH slots, one
// slot a cycle, through the launch register and each slot's register to the
// result register; the strobe rises as busy falls, and only then can the
// next operation be taken. An insert into a full list and an unused
// operation code change nothing and answer in the next cycle without
// raising busy. Each result is shown for one cycle only and cannot be
// held off; entry_count is the count after the operation.
// ----------------------------------------------------------------------------
module ordered_list_engine #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [2:0]                            req_operation,
   input  logic signed [ole_pkg::IN_WIDTH-1:0]   req_value,
   output logic                                  rsp_valid,
   output logic                                  rsp_hit,
   output logic                                  rsp_full_res,
   output logic [ole_pkg::COUNT_WIDTH-1:0]       rsp_entry_count
);
   import ole_pkg::*;

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);

   ctl_type                 chain_ctl   [DEPTH+1];
   logic signed [WIDTH-1:0] chain_v     [DEPTH+1];
   logic [WIDTH-1:0]        chain_carry [DEPTH+1];
   logic [WIDTH-1:0]        cell_value  [DEPTH];
   logic [DEPTH:0]          tok_act;

   ctl_type                 launch_ctl_ff;
   logic signed [WIDTH-1:0] launch_v_ff;
   logic                    busy_ff;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic                    rsp_valid_ff, rsp_hit_ff, rsp_full_ff;
   logic [COUNT_WIDTH-1:0]  rsp_count_ff;

   logic                    accept, launch_go, refuse, is_insert;
   logic signed [WIDTH-1:0] req_norm;
   op_type                  req_op;
   ctl_type                 tail;

   assign accept   = start && !busy_ff;
   assign req_norm = WIDTH'(req_value);
   assign req_op   = op_type'(req_operation);
   assign tail     = chain_ctl[DEPTH];

   always_comb begin
      launch_go = 1'b0;
      refuse    = 1'b0;
      case (req_op)
         OP_FRONT, OP_BACK, OP_ORDERED: begin
            refuse    = (count_ff == FULL);
            launch_go = !refuse;
         end
         OP_SEARCH, OP_REMOVE: launch_go = 1'b1;
         default: ;
      endcase
   end

   always_comb begin
      is_insert = 1'b0;
      case (tail.kind)
         OP_FRONT, OP_BACK, OP_ORDERED: is_insert = 1'b1;
         default: is_insert = 1'b0;
      endcase
   end

   always_comb begin
      count_in = count_ff;
      if (tail.act) begin
         if (is_insert) begin
            count_in = count_ff + 1'b1;
         end else if (tail.kind == OP_REMOVE && tail.shift) begin
            count_in = count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      launch_v_ff <= req_norm;
      if (reset) begin
         launch_ctl_ff <= '0;
         busy_ff       <= 1'b0;
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         rsp_hit_ff    <= 1'b0;
         rsp_full_ff   <= 1'b0;
         rsp_count_ff  <= '0;
      end else begin
         launch_ctl_ff <= '0;
         rsp_valid_ff  <= 1'b0;
         count_ff      <= count_in;
         if (accept && launch_go) begin
            launch_ctl_ff.act  <= 1'b1;
            launch_ctl_ff.kind <= req_op;
            busy_ff            <= 1'b1;
         end else if (accept) begin
            rsp_valid_ff <= 1'b1;
            rsp_hit_ff   <= 1'b0;
            rsp_full_ff  <= refuse;
            rsp_count_ff <= COUNT_WIDTH'(count_ff);
         end else if (tail.act) begin
            busy_ff      <= 1'b0;
            rsp_valid_ff <= 1'b1;
            rsp_hit_ff   <= is_insert || tail.shift;
            rsp_full_ff  <= 1'b0;
            rsp_count_ff <= COUNT_WIDTH'(count_in);
         end
      end
   end

   assign chain_ctl[0]   = launch_ctl_ff;
   assign chain_v[0]     = launch_v_ff;
   assign chain_carry[0] = '0;

   genvar gi;
   generate
      for (gi = 0; gi < DEPTH; gi++) begin : g_cell
         logic [WIDTH-1:0] nxt;
         if (gi < DEPTH - 1) begin : g_mid
            assign nxt = cell_value[gi+1];
         end else begin : g_last
            assign nxt = '0;
         end
         ole_cell #(
            .WIDTH (WIDTH),
            .CNT_W (CNT_W),
            .INDEX (gi)
         ) u_cell (
            .clock     (clock),
            .reset     (reset),
            .count     (count_ff),
            .ctl_i     (chain_ctl[gi]),
            .v_i       (chain_v[gi]),
            .carry_i   (chain_carry[gi]),
            .nxt_value (nxt),
            .value_o   (cell_value[gi]),
            .ctl_o     (chain_ctl[gi+1]),
            .v_o       (chain_v[gi+1]),
            .carry_o   (chain_carry[gi+1])
         );
      end
      for (gi = 0; gi <= DEPTH; gi++) begin : g_act
         assign tok_act[gi] = chain_ctl[gi].act;
      end
   endgenerate

   assign busy            = busy_ff;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_full_res    = rsp_full_ff;
   assign rsp_entry_count = rsp_count_ff;

`ifndef NO_ASSERTIONS
   a_one_token: assert property (@(posedge clock) disable iff (reset)
      $countones(tok_act) <= 1)
      else $error("more than one transaction in the cell chain");

   a_tail_busy: assert property (@(posedge clock) disable iff (reset)
      tail.act |-> busy_ff)
      else $error("transaction reached chain end while not busy");

   a_busy_quiet: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !rsp_valid_ff)
      else $error("result strobe while a transaction is in flight");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL)
      else $error("entry count beyond depth");

   a_quick_rsp: assert property (@(posedge clock) disable iff (reset)
      (accept && !launch_go) |=> (rsp_valid_ff && !rsp_hit_ff && !busy_ff))
      else $error("refused or unused operation did not answer at once");
`endif

endmodule
